@@ rtl/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// shared constants, types and helpers of the size class allocator
// ----------------------------------------------------------------------------
package sca_pkg;

   localparam int PAGE_BYTES_LOG2 = 12;
   localparam int MIN_CLASS_LOG2  = 4;
   localparam int NUM_CLASSES     = 8;
   localparam int REGION_PAGES    = 256;
   localparam int NUM_KINDS       = 3;

   localparam int SIZE_W  = 21;
   localparam int ALIGN_W = 16;
   localparam int KIND_W  = 2;
   localparam int ADDR_W  = 20;
   localparam int LOG_W   = 5;

   localparam int NFP_W      = $clog2(REGION_PAGES + 1);
   localparam int BYTE_W     = PAGE_BYTES_LOG2 + NFP_W;
   localparam int LINK_AW    = PAGE_BYTES_LOG2 - MIN_CLASS_LOG2 + $clog2(REGION_PAGES);
   localparam int LINK_DEPTH = REGION_PAGES << (PAGE_BYTES_LOG2 - MIN_CLASS_LOG2);
   localparam int HEAD_W     = LINK_AW + 1;
   localparam int PG_W       = SIZE_W - PAGE_BYTES_LOG2 + 1;
   localparam int CLS_W      = $clog2(NUM_CLASSES + 1);
   localparam int NUM_SLOTS  = NUM_KINDS * NUM_CLASSES;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);

   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RODATA = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CODE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   // classified request handed from front to back
   typedef struct packed {
      logic                       fail;
      logic                       is_page;
      logic [PG_W-1:0]            pages;
      logic [KIND_W-1:0]          kind;
      logic [CLS_W-1:0]           cls;
      logic [PAGE_BYTES_LOG2-1:0] rest;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LINK,
      ST_SPLIT,
      ST_RESP
   } back_state_type;

   // position of the highest set bit, zero for zero
   function automatic logic [LOG_W-1:0] floor_log2(input logic [SIZE_W-1:0] v);
      logic [LOG_W-1:0] r;
      r = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (v[i]) begin
            r = LOG_W'(i);
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/sca_ram.sv @@
// ----------------------------------------------------------------------------
// sca_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/sca_front.sv @@
// ----------------------------------------------------------------------------
// sca_front
// classifies a request: class, page count, tail bytes, early failure
// ----------------------------------------------------------------------------
module sca_front import sca_pkg::*; (
   input  logic [SIZE_W-1:0]  size_bytes,
   input  logic [ALIGN_W-1:0] alignment,
   input  logic [KIND_W-1:0]  region_kind,
   output item_type           item
);

   logic [LOG_W-1:0]           align_log2;
   logic [LOG_W-1:0]           size_log2;
   logic [LOG_W-1:0]           cls_log2;
   logic [LOG_W-1:0]           cls_idx;
   logic [SIZE_W-1:0]          size_m1;
   logic                       is_page;
   logic [PAGE_BYTES_LOG2-1:0] alloc_low;

   always_comb begin
      align_log2 = floor_log2(SIZE_W'(alignment));
      if (align_log2 > LOG_W'(PAGE_BYTES_LOG2)) begin
         align_log2 = LOG_W'(PAGE_BYTES_LOG2);
      end
      size_m1 = size_bytes - SIZE_W'(1);
      // ceiling log2, at least the smallest class
      size_log2 = (size_bytes <= SIZE_W'(1)) ? '0 : floor_log2(size_m1) + LOG_W'(1);
      if (size_log2 < LOG_W'(MIN_CLASS_LOG2)) begin
         size_log2 = LOG_W'(MIN_CLASS_LOG2);
      end
      cls_log2 = (align_log2 > size_log2) ? align_log2 : size_log2;
      is_page  = cls_log2 >= LOG_W'(PAGE_BYTES_LOG2);
      cls_idx  = cls_log2 - LOG_W'(MIN_CLASS_LOG2);
      alloc_low = is_page ? '0 : (PAGE_BYTES_LOG2'(1) << cls_log2);

      item.fail    = (size_bytes == '0) || (region_kind == KIND_NONE) ||
                     (!is_page && (cls_idx >= LOG_W'(NUM_CLASSES)));
      item.is_page = is_page;
      item.pages   = PG_W'(size_m1 >> PAGE_BYTES_LOG2) + PG_W'(1);
      item.kind    = region_kind;
      item.cls     = CLS_W'(cls_idx);
      item.rest    = alloc_low - size_bytes[PAGE_BYTES_LOG2-1:0];
   end

endmodule

@@ rtl/sca_queue.sv @@
// ----------------------------------------------------------------------------
// sca_queue
// two entry queue between classifier and executor
// ----------------------------------------------------------------------------
module sca_queue import sca_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count missed a push");

endmodule

@@ rtl/sca_back.sv @@
// ----------------------------------------------------------------------------
// sca_back
// executes a classified request: page bump, list pop, class page, tail split
// ----------------------------------------------------------------------------
module sca_back import sca_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  item_type          item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_address,
   output logic              rsp_failed
);

   back_state_type state_ff, state_in;
   item_type       work_ff, work_in;
   logic [BYTE_W-1:0]          ptr_ff, ptr_in;
   logic [BYTE_W-1:0]          end_ff, end_in;
   logic [PAGE_BYTES_LOG2-1:0] rest_ff, rest_in;
   logic [CLS_W-1:0]           c_ff, c_in;
   logic                       fail_ff, fail_in;
   logic [NFP_W-1:0]           nfp_ff, nfp_in;
   logic                       head_valid_ff [NUM_SLOTS];
   logic [LINK_AW-1:0]         head_idx_ff   [NUM_SLOTS];
   logic [BYTE_W-1:0]          cursor_ff     [NUM_SLOTS];
   logic [BYTE_W-1:0]          limit_ff      [NUM_SLOTS];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]          rsp_address_ff;
   logic                       rsp_failed_ff;

   logic [SLOT_W-1:0]      slot, split_slot, head_sel;
   logic                   head_v;
   logic [LINK_AW-1:0]     head_i;
   logic [BYTE_W-1:0]      alloc, base, cls_bytes;
   logic [NFP_W-1:0]       avail;
   logic                   page_ok, new_page, page_left, take;
   logic [BYTE_W-1:0]      end_take;
   logic [LINK_AW-1:0]     push_idx;
   logic                   rsp_free;
   logic                   ram_we, ram_re;
   logic [HEAD_W-1:0]      ram_rdata;

   // shared decode for the exec and split steps
   always_comb begin
      slot       = SLOT_W'(int'(work_ff.kind) * NUM_CLASSES + int'(work_ff.cls));
      split_slot = SLOT_W'(int'(work_ff.kind) * NUM_CLASSES + int'(c_ff));
      head_sel   = (state_ff == ST_SPLIT) ? split_slot : slot;
      head_v     = head_valid_ff[head_sel];
      head_i     = head_idx_ff[head_sel];
      alloc      = BYTE_W'(1) << (int'(work_ff.cls) + MIN_CLASS_LOG2);
      base       = BYTE_W'(nfp_ff) << PAGE_BYTES_LOG2;
      avail      = NFP_W'(REGION_PAGES) - nfp_ff;
      page_ok    = PG_W'(avail) >= work_ff.pages || (PG_W < NFP_W);
      if (PG_W < NFP_W) begin
         page_ok = NFP_W'(work_ff.pages) <= avail;
      end
      new_page   = cursor_ff[slot] == limit_ff[slot];
      page_left  = nfp_ff < NFP_W'(REGION_PAGES);
      cls_bytes  = BYTE_W'(1) << (int'(c_ff) + MIN_CLASS_LOG2);
      take       = BYTE_W'(rest_ff) >= cls_bytes;
      end_take   = end_ff - cls_bytes;
      push_idx   = end_take[MIN_CLASS_LOG2 +: LINK_AW];
      rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (item_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (work_ff.fail) begin
               state_in = ST_RESP;
            end else if (work_ff.is_page) begin
               state_in = page_ok ? ST_SPLIT : ST_RESP;
            end else if (head_v) begin
               state_in = ST_LINK;
            end else if (new_page && !page_left) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SPLIT;
            end
         end
         ST_LINK:  state_in = ST_SPLIT;
         ST_SPLIT: if (c_ff == '0) state_in = ST_RESP;
         ST_RESP:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      item_ready = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      case (state_ff)
         ST_IDLE:  item_ready = 1'b1;
         ST_EXEC:  ram_re = !work_ff.fail && !work_ff.is_page && head_v;
         ST_SPLIT: ram_we = take;
         default:  item_ready = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      work_in      = work_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      rest_in      = rest_ff;
      c_in         = c_ff;
      fail_in      = fail_ff;
      nfp_in       = nfp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               work_in = item;
            end
         end
         ST_EXEC: begin
            rest_in = work_ff.rest;
            c_in    = CLS_W'(NUM_CLASSES - 1);
            fail_in = 1'b0;
            if (work_ff.fail) begin
               fail_in = 1'b1;
            end else if (work_ff.is_page) begin
               fail_in = !page_ok;
               ptr_in  = base;
               if (page_ok) begin
                  nfp_in = nfp_ff + NFP_W'(work_ff.pages);
               end
               end_in  = BYTE_W'(nfp_in) << PAGE_BYTES_LOG2;
            end else if (head_v) begin
               ptr_in = BYTE_W'(head_i) << MIN_CLASS_LOG2;
               end_in = ptr_in + alloc;
            end else if (new_page) begin
               fail_in = !page_left;
               ptr_in  = base;
               end_in  = base + alloc;
               if (page_left) begin
                  nfp_in = nfp_ff + NFP_W'(1);
               end
            end else begin
               ptr_in = cursor_ff[slot];
               end_in = cursor_ff[slot] + alloc;
            end
         end
         ST_SPLIT: begin
            if (take) begin
               end_in  = end_take;
               rest_in = rest_ff - PAGE_BYTES_LOG2'(cls_bytes);
            end
            c_in = c_ff - CLS_W'(1);
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: work_in = work_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nfp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            head_valid_ff[i] <= 1'b0;
            cursor_ff[i]     <= '0;
            limit_ff[i]      <= '0;
         end
      end else begin
         state_ff     <= state_in;
         nfp_ff       <= nfp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_EXEC && !work_ff.fail && !work_ff.is_page && !head_v) begin
            if (new_page && page_left) begin
               cursor_ff[slot] <= base + alloc;
               limit_ff[slot]  <= base + (BYTE_W'(1) << PAGE_BYTES_LOG2);
            end else if (!new_page) begin
               cursor_ff[slot] <= cursor_ff[slot] + alloc;
            end
         end
         if (state_ff == ST_LINK) begin
            head_valid_ff[slot] <= ram_rdata[LINK_AW];
         end
         if (state_ff == ST_SPLIT && take) begin
            head_valid_ff[split_slot] <= 1'b1;
         end
      end
      work_ff <= work_in;
      ptr_ff  <= ptr_in;
      end_ff  <= end_in;
      rest_ff <= rest_in;
      c_ff    <= c_in;
      fail_ff <= fail_in;
      if (state_ff == ST_LINK) begin
         head_idx_ff[slot] <= ram_rdata[LINK_AW-1:0];
      end
      if (state_ff == ST_SPLIT && take) begin
         head_idx_ff[split_slot] <= push_idx;
      end
      if (state_ff == ST_RESP && rsp_free) begin
         rsp_address_ff <= fail_ff ? '0 : ADDR_W'(ptr_ff);
         rsp_failed_ff  <= fail_ff;
      end
   end

   sca_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (push_idx),
      .wr_data    ({head_v, head_i}),
      .rd_en      (ram_re),
      .rd_addr    (head_i),
      .rd_data_ff (ram_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_failed  = rsp_failed_ff;

   a_nfp_bound: assert property (@(posedge clock) disable iff (reset)
      nfp_ff <= NFP_W'(REGION_PAGES)) else $error("page pointer past region");
   a_write_in_split: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_SPLIT)) else $error("link write outside split");
   a_link_after_read: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> (state_ff == ST_LINK)) else $error("link read not consumed");
   a_pages_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC) |=> (nfp_ff == $past(nfp_ff)))
      else $error("page pointer moved outside exec");

endmodule

@@ rtl/size_class_allocator_core.sv @@
// a refused word passes dequeue, exec and response load; a grant also runs the
// split loop over every size class, and a grant popped from a free list adds a
// link read before it; the back takes a new word only once the response of the
// last one is loaded, while the queue holds up to two words, and the split loop
// writes the free-list links through the single link ram port
// reset: synchronous, active high; empties all free lists, zeroes page pointers
// ----------------------------------------------------------------------------
// size_class_allocator_core
// segregated free list allocator: classifier, two entry queue, executor
// ----------------------------------------------------------------------------
module size_class_allocator_core import sca_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request words
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [SIZE_W-1:0]  req_size_bytes,
   input  logic [ALIGN_W-1:0] req_alignment,
   input  logic [KIND_W-1:0]  req_region_kind,
   // response words
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ADDR_W-1:0]  rsp_address,
   output logic               rsp_failed
);

   // classified word from the front end
   item_type front_item;
   // queue head toward the executor
   item_type back_item;
   logic     back_valid;
   logic     back_ready;

   // front: purely combinational class, page count and tail computation
   sca_front u_front (
      .size_bytes  (req_size_bytes),
      .alignment   (req_alignment),
      .region_kind (req_region_kind),
      .item        (front_item)
   );

   // decoupling queue, lets the front accept while the back is busy
   sca_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   // back: allocation state, link ram and the response register
   sca_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (back_valid),
      .item_ready  (back_ready),
      .item        (back_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_address (rsp_address),
      .rsp_failed  (rsp_failed)
   );

   // a failed response always carries a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_failed) |-> (rsp_address == '0))
      else $error("failed response with nonzero offset");
   // a zero size request never reaches the back as a grant
   a_zero_fails: assert property (@(posedge clock) disable iff (reset)
      (req_valid && (req_size_bytes == '0)) |-> front_item.fail)
      else $error("zero size not flagged");
   a_bad_kind_fails: assert property (@(posedge clock) disable iff (reset)
      (req_valid && (req_region_kind == KIND_NONE)) |-> front_item.fail)
      else $error("unknown kind not flagged");

endmodule
